// ===== hdl/ocr_pkg.sv =====
// Package for the opacity curve resampler: sizes, state encoding and a helper function.
package ocr_pkg;

  localparam int MAX_POINTS     = 64;
  localparam int MAX_RESOLUTION = 1024;
  localparam int FRAC_BITS      = 16;

  localparam int PT_W     = 16;
  localparam int PT_AW    = $clog2(MAX_POINTS);
  localparam int SPAN_W   = $clog2(MAX_RESOLUTION);
  localparam int SAMP_W   = 10;
  localparam int NP_W     = 7;
  localparam int RES_W    = 11;
  localparam int POS_W    = SPAN_W + PT_AW;
  localparam int DIV_W    = POS_W + FRAC_BITS;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam int PROD_W   = PT_W + FRAC_BITS;
  localparam int ACC_W    = PROD_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [PT_W-1:0] Q_ONE = PT_W'(32768);
  localparam logic [PT_W-1:0] Q_HALF = PT_W'(16384);

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = CFG_IDX_W'(1);

  localparam logic [NP_W-1:0]  NUM_POINTS_RST = NP_W'(3);
  localparam logic [RES_W-1:0] RESOLUTION_RST = RES_W'(256);

  localparam logic [0:0] KIND_WRITE  = 1'b0;
  localparam logic [0:0] KIND_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADDR,
    ST_LO,
    ST_HI,
    ST_PROD,
    ST_ACC
  } ocr_state_e;

  function automatic logic [PT_W-1:0] reset_point(logic [PT_AW-1:0] addr);
    logic [PT_W-1:0] v;
    v = '0;
    if (addr == PT_AW'(1)) begin
      v = Q_HALF;
    end else if (addr == PT_AW'(2)) begin
      v = Q_ONE;
    end
    return v;
  endfunction

endpackage

// ===== hdl/ocr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ocr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/opacity_curve_linear_resampler.sv =====
// Top level of the opacity curve resampler: control point table and sample interpolator.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | kind, point_index, point_value, sample_index
//  out     | output    | out_valid_o/out_stall_i | sample_number, opacity
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A point write does not stall the input. A sample request stalls the input after its transfer
// until the interpolator is idle again; the divider works out two quotient bits a cycle, then
// two reads of the point memory's read port fetch the lower and upper points.
// After reset the table holds 0, 0.5 and 1.0 in its first slots through per-slot valid bits.
// A finished sample waits in the output register while the next item is taken in, and the last
// step waits for as long as out_stall_i holds an earlier result in that register.
module opacity_curve_linear_resampler
  import ocr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_kind_i,
  input  logic [PT_AW-1:0]      in_point_index_i,
  input  logic [PT_W-1:0]       in_point_value_i,
  input  logic [SAMP_W-1:0]     in_sample_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SAMP_W-1:0]     out_sample_number_o,
  output logic [PT_W-1:0]       out_opacity_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ocr_state_e state_q, state_d;

  logic [NP_W-1:0]       num_points_q;
  logic [RES_W-1:0]      resolution_q;
  logic [MAX_POINTS-1:0] pt_valid_q;

  logic [SAMP_W-1:0] samp_q;
  logic [PT_AW-1:0]  pm1_q;
  logic [SPAN_W-1:0] span_q;
  logic [SPAN_W-1:0] rem_q;
  logic [DIV_W-1:0]  div_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [PT_AW-1:0]  qh_q;
  logic [PT_W-1:0]   lo_q, hi_q;
  logic              up_q;
  logic [PROD_W-1:0] prod_q;
  logic              rd_valid_q;
  logic [PT_AW-1:0]  rd_addr_q;

  logic              out_valid_q;
  logic [SAMP_W-1:0] out_samp_q;
  logic [PT_W-1:0]   out_opa_q;

  logic in_xfer, out_xfer, wr_en, rd_en, out_load;
  logic [PT_AW-1:0]  rd_addr;
  logic [PT_W-1:0]   wr_data, rd_data, pt_data;
  logic [PT_AW-1:0]  pm1_d;
  logic [SPAN_W-1:0] span_d;
  logic [SAMP_W-1:0] samp_d;
  logic [POS_W-1:0]  quot;
  logic [PT_AW-1:0]  q_clamp, qh_d;
  logic [SPAN_W:0]   step1, step2;
  logic [PT_W-1:0]   diff;
  logic [ACC_W-1:0]  lo_ext, acc;

  function automatic logic [SPAN_W:0] div_step(logic [SPAN_W-1:0] rem, logic b,
                                               logic [SPAN_W-1:0] span);
    logic [SPAN_W:0] t;
    logic [SPAN_W:0] r;
    t = {rem, b};
    if (t >= {1'b0, span}) begin
      r = {SPAN_W'(t - {1'b0, span}), 1'b1};
    end else begin
      r = {t[SPAN_W-1:0], 1'b0};
    end
    return r;
  endfunction

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign wr_en       = in_xfer && (in_kind_i == KIND_WRITE);
  assign wr_data     = (in_point_value_i > Q_ONE) ? Q_ONE : in_point_value_i;

  ocr_ram #(
    .WIDTH(PT_W),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(in_point_index_i),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign pt_data = rd_valid_q ? rd_data : reset_point(rd_addr_q);

  always_comb begin
    if (num_points_q < NP_W'(2)) begin
      pm1_d = PT_AW'(1);
    end else if (num_points_q > NP_W'(MAX_POINTS)) begin
      pm1_d = PT_AW'(MAX_POINTS - 1);
    end else begin
      pm1_d = PT_AW'(num_points_q - NP_W'(1));
    end
    if (resolution_q < RES_W'(2)) begin
      span_d = SPAN_W'(1);
    end else if (resolution_q > RES_W'(MAX_RESOLUTION)) begin
      span_d = SPAN_W'(MAX_RESOLUTION - 1);
    end else begin
      span_d = SPAN_W'(resolution_q - RES_W'(1));
    end
    samp_d = (in_sample_index_i > SAMP_W'(span_d)) ? SAMP_W'(span_d) : in_sample_index_i;
  end

  always_comb begin
    step1 = div_step(rem_q, div_q[DIV_W-1], span_q);
    step2 = div_step(step1[SPAN_W:1], div_q[DIV_W-2], span_q);
  end

  always_comb begin
    quot    = div_q[DIV_W-1:FRAC_BITS];
    q_clamp = (quot >= POS_W'(MAX_POINTS)) ? PT_AW'(MAX_POINTS - 1) : quot[PT_AW-1:0];
    qh_d    = (quot < POS_W'(pm1_q)) ? quot[PT_AW-1:0] + PT_AW'(1) : pm1_q;
  end

  always_comb begin
    diff   = (hi_q >= lo_q) ? hi_q - lo_q : lo_q - hi_q;
    lo_ext = {1'b0, lo_q, {FRAC_BITS{1'b0}}};
    if (up_q) begin
      acc = lo_ext + {1'b0, prod_q};
    end else begin
      acc = lo_ext - {1'b0, prod_q};
    end
    acc = acc + (ACC_W'(1) << (FRAC_BITS - 1));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_kind_i == KIND_SAMPLE)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: state_d = ST_LO;
      ST_LO:   state_d = ST_HI;
      ST_HI:   state_d = ST_PROD;
      ST_PROD: state_d = ST_ACC;
      ST_ACC: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = q_clamp;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_ADDR: rd_en = 1'b1;
      ST_LO: begin
        rd_en   = 1'b1;
        rd_addr = qh_q;
      end
      ST_ACC:  out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      num_points_q <= NUM_POINTS_RST;
      resolution_q <= RESOLUTION_RST;
      pt_valid_q   <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_NUM_POINTS: num_points_q <= NP_W'(cfg_data_i);
          REG_RESOLUTION: resolution_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (wr_en) begin
        pt_valid_q[in_point_index_i] <= 1'b1;
      end
      if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      samp_q <= samp_d;
      pm1_q  <= pm1_d;
      span_q <= span_d;
    end
    if (rd_en) begin
      rd_valid_q <= pt_valid_q[rd_addr];
      rd_addr_q  <= rd_addr;
    end
    unique case (state_q)
      ST_MUL: begin
        div_q <= {POS_W'(samp_q) * POS_W'(pm1_q), {FRAC_BITS{1'b0}}};
        rem_q <= '0;
      end
      ST_DIV: begin
        div_q <= {div_q[DIV_W-3:0], step1[0], step2[0]};
        rem_q <= step2[SPAN_W:1];
      end
      ST_ADDR: begin
        frac_q <= div_q[FRAC_BITS-1:0];
        qh_q   <= qh_d;
      end
      ST_LO:   lo_q <= pt_data;
      ST_HI:   hi_q <= pt_data;
      ST_PROD: begin
        up_q   <= hi_q >= lo_q;
        prod_q <= PROD_W'(diff) * PROD_W'(frac_q);
      end
      default: ;
    endcase
    if (out_load) begin
      out_samp_q <= samp_q;
      out_opa_q  <= acc[PROD_W-1:FRAC_BITS];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_sample_number_o = out_samp_q;
  assign out_opacity_o       = out_opa_q;

`ifndef SYNTHESIS
  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_kind_i == KIND_SAMPLE) |=> state_q == ST_MUL)
    else $error("Sample request did not start the multiply step.");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (cnt_q == CNT_W'(DIV_STEPS - 1)) |=> state_q == ST_ADDR)
    else $error("Divider did not finish after its last step.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_ACC)
    else $error("Result appeared without a finished interpolation.");

  a_opacity_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_opa_q <= Q_ONE)
    else $error("Interpolated opacity exceeds one.");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> pt_valid_q[$past(in_point_index_i)])
    else $error("Point write did not mark its slot valid.");
`endif

endmodule

// ===== tb/opacity_curve_checker.sv =====
// Checker for the opacity curve resampler: watches all channels, predicts samples and compares.
module opacity_curve_checker
  import ocr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  in_kind_i,
  input  logic [PT_AW-1:0]      in_point_index_i,
  input  logic [PT_W-1:0]       in_point_value_i,
  input  logic [SAMP_W-1:0]     in_sample_index_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [SAMP_W-1:0]     out_sample_number_i,
  input  logic [PT_W-1:0]       out_opacity_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    outstanding_o,
  output int                    mismatch_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SAMP_W-1:0] sample_number;
    logic [PT_W-1:0]   opacity;
  } sample_result_t;

  logic [PT_W-1:0]  curve_points [MAX_POINTS];
  logic [NP_W-1:0]  points_reg;
  logic [RES_W-1:0] resolution_reg;
  sample_result_t   pending_samples [$];
  sample_result_t   want;
  int               mismatch_count = 0;
  int unsigned      used_points;
  int unsigned      used_res;
  int unsigned      used_sample;

  assign mismatch_count_o = mismatch_count;

  function automatic int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PT_W-1:0] expected_opacity(int unsigned s, int unsigned p,
                                                       int unsigned r);
    longint unsigned span, pos, q, rem, frac, qh, lo, hi, acc;
    span = 64'(r - 1);
    pos  = 64'(s) * 64'(p - 1);
    q    = pos / span;
    rem  = pos % span;
    frac = (rem << FRAC_BITS) / span;
    qh   = (q + 1 < 64'(p)) ? q + 1 : 64'(p - 1);
    if (q >= MAX_POINTS) q = MAX_POINTS - 1;
    if (qh >= MAX_POINTS) qh = MAX_POINTS - 1;
    lo = 64'(curve_points[q]);
    hi = 64'(curve_points[qh]);
    if (hi >= lo) begin
      acc = (lo << FRAC_BITS) + (hi - lo) * frac;
    end else begin
      acc = (lo << FRAC_BITS) - (lo - hi) * frac;
    end
    acc += 64'(1) << (FRAC_BITS - 1);
    return PT_W'(acc >> FRAC_BITS);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        curve_points[i] = '0;
      end
      curve_points[1] = Q_HALF;
      curve_points[2] = Q_ONE;
      points_reg      = NUM_POINTS_RST;
      resolution_reg  = RESOLUTION_RST;
      pending_samples.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_samples.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: sample %0d opacity %0d",
                                    out_sample_number_i, out_opacity_i));
        end else begin
          want = pending_samples.pop_front();
          if (out_sample_number_i !== want.sample_number) begin
            report_mismatch($sformatf("sample_number %0d, expected %0d",
                                      out_sample_number_i, want.sample_number));
          end
          if (out_opacity_i !== want.opacity) begin
            report_mismatch($sformatf("opacity %0d for sample %0d, expected %0d",
                                      out_opacity_i, want.sample_number, want.opacity));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_kind_i == KIND_WRITE) begin
          curve_points[in_point_index_i] = (in_point_value_i > Q_ONE) ? Q_ONE : in_point_value_i;
        end else begin
          used_points = bound(32'(points_reg), 2, MAX_POINTS);
          used_res    = bound(32'(resolution_reg), 2, MAX_RESOLUTION);
          used_sample = (32'(in_sample_index_i) > used_res - 1) ? used_res - 1
                                                                : 32'(in_sample_index_i);
          want.sample_number = SAMP_W'(used_sample);
          want.opacity       = expected_opacity(used_sample, used_points, used_res);
          pending_samples.push_back(want);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_NUM_POINTS: begin
            points_reg = cfg_data_i[NP_W-1:0];
          end
          REG_RESOLUTION: begin
            resolution_reg = cfg_data_i[RES_W-1:0];
          end
          default: begin
          end
        endcase
      end
      outstanding_o <= pending_samples.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the opacity curve resampler: clock, reset, stimulus and verdict.
module testbench
  import ocr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 125;
  localparam int PHASE_COUNT   = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  in_kind      = KIND_WRITE;
  logic [PT_AW-1:0]      in_point_index  = '0;
  logic [PT_W-1:0]       in_point_value  = '0;
  logic [SAMP_W-1:0]     in_sample_index = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [SAMP_W-1:0]     out_sample_number;
  logic [PT_W-1:0]       out_opacity;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int          outstanding;
  int          mismatches;
  int          cycle_count = 0;
  int unsigned stall_left  = 0;
  logic        quiet_recv  = 1'b0;
  logic        quiet_send  = 1'b0;
  int unsigned live_points = 3;
  int unsigned live_res    = 256;

  opacity_curve_linear_resampler i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_kind_i           (in_kind),
    .in_point_index_i    (in_point_index),
    .in_point_value_i    (in_point_value),
    .in_sample_index_i   (in_sample_index),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_sample_number_o (out_sample_number),
    .out_opacity_o       (out_opacity),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  opacity_curve_checker i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .in_kind_i           (in_kind),
    .in_point_index_i    (in_point_index),
    .in_point_value_i    (in_point_value),
    .in_sample_index_i   (in_sample_index),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .out_sample_number_i (out_sample_number),
    .out_opacity_i       (out_opacity),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .outstanding_o       (outstanding),
    .mismatch_count_o    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    int unsigned pick;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet_recv) begin
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_stall <= 1'b0;
      end else if (pick < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 50);
      end
    end
  end

  function automatic int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (quiet_send || pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic kind, logic [PT_AW-1:0] slot, logic [PT_W-1:0] value,
                           logic [SAMP_W-1:0] sample);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_point_index  <= slot;
    in_point_value  <= value;
    in_sample_index <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (index)
      REG_NUM_POINTS: begin
        live_points = bound(32'(data[NP_W-1:0]), 2, MAX_POINTS);
      end
      REG_RESOLUTION: begin
        live_res = bound(32'(data[RES_W-1:0]), 2, MAX_RESOLUTION);
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic random_items(int unsigned count, int unsigned pause_at);
    logic [PT_AW-1:0]  slot;
    logic [PT_W-1:0]   value;
    logic [SAMP_W-1:0] sample;
    int unsigned       pick;
    for (int unsigned n = 0; n < count; n++) begin
      if (pause_at != 0 && n == pause_at) begin
        wait_idle();
      end
      slot   = PT_AW'($urandom_range(0, live_points - 1));
      sample = SAMP_W'($urandom_range(0, live_res - 1));
      value  = PT_W'($urandom_range(0, 32768));
      if ($urandom_range(0, 7) == 0) begin
        slot   = PT_AW'($urandom);
        sample = SAMP_W'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        value = '0;
      end else if (pick == 1) begin
        value = Q_ONE;
      end else if (pick == 2) begin
        value = PT_W'($urandom);
      end
      if ($urandom_range(0, 99) < 50) begin
        send_item(KIND_SAMPLE, PT_AW'($urandom), PT_W'($urandom), sample);
      end else begin
        send_item(KIND_WRITE, slot, value, SAMP_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] np_data;
    logic [CFG_DATA_W-1:0] res_data;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(0));
    send_item(KIND_SAMPLE, '1, '1, SAMP_W'(255));
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(1023));
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(128));
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(1));
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(127));
    send_item(KIND_WRITE, PT_AW'(0), PT_W'(65535), '0);
    send_item(KIND_WRITE, PT_AW'(1), PT_W'(32769), '1);
    send_item(KIND_WRITE, PT_AW'(2), PT_W'(0), '0);
    send_item(KIND_WRITE, PT_AW'(63), PT_W'(12345), '0);
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(64));
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(192));
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(200));
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(255));
    send_item(KIND_WRITE, PT_AW'(0), Q_ONE, '0);
    send_item(KIND_WRITE, PT_AW'(1), PT_W'(1), '0);
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(3));
    send_item(KIND_SAMPLE, '0, '0, SAMP_W'(130));

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_idle();
      case (ph)
        0: begin np_data = 11'd2;    res_data = 11'd2;    end
        1: begin np_data = 11'd64;   res_data = 11'd1024; end
        2: begin np_data = 11'd0;    res_data = 11'd0;    end
        3: begin np_data = 11'h7FF;  res_data = 11'd2047; end
        4: begin np_data = 11'd1;    res_data = 11'd1;    end
        5: begin np_data = 11'd65;   res_data = 11'd1025; end
        6: begin np_data = 11'h440;  res_data = 11'd2;    end
        7: begin np_data = 11'h382;  res_data = 11'd1024; end
        default: begin
          np_data  = {CFG_DATA_W'($urandom_range(0, 15)) << NP_W}
                     | CFG_DATA_W'($urandom_range(2, 64));
          res_data = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                 : CFG_DATA_W'($urandom_range(2, 64));
        end
      endcase
      write_reg((ph % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
      if (ph % 2 == 0) begin
        write_reg(REG_NUM_POINTS, np_data);
        write_reg(REG_RESOLUTION, res_data);
      end else begin
        write_reg(REG_RESOLUTION, res_data);
        write_reg(REG_NUM_POINTS, np_data);
      end
      quiet_send = (ph % 3 == 1);
      quiet_recv <= (ph % 3 == 2);
      random_items(PHASE_ITEMS, (ph == 4 || ph == 9) ? 60 : 0);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
